>>> sv/tli_pkg.sv
// shared types and constants of the table linear interpolator
// item structs, controller command and status structs, select codes
// no dependencies
package tli_pkg;

  localparam int unsigned TLEN_W = 9;
  localparam int unsigned QUO_W  = 33;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_TABLE_LENGTH = 1'b0;
  localparam logic REG_LEFT_VALUE   = 1'b1;

  localparam logic [1:0] REGION_BELOW    = 2'd0;
  localparam logic [1:0] REGION_INTERIOR = 2'd1;
  localparam logic [1:0] REGION_AT_LAST  = 2'd2;
  localparam logic [1:0] REGION_ABOVE    = 2'd3;

  typedef enum logic [1:0] {
    ADDR_LAST,
    ADDR_MID,
    ADDR_LOM1,
    ADDR_LO
  } addr_sel_e;

  typedef enum logic [1:0] {
    RES_LEFT,
    RES_ABOVE,
    RES_AT,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic               kind;
    logic [7:0]         point_index;
    logic signed [31:0] domain_value;
    logic signed [31:0] point_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic [1:0]         region;
  } out_item_t;

  typedef struct packed {
    logic      write;
    logic      capture;
    logic      rd_en;
    addr_sel_e rd_sel;
    logic      mid_load;
    logic      keep_last;
    logic      step_search;
    logic      take_p0;
    logic      delta;
    logic      mag;
    logic      mul;
    logic      sum;
    logic      check;
    logic      div_step;
    logic      res_load;
    res_sel_e  res_sel;
  } cmd_t;

  typedef struct packed {
    logic gt_last;
    logic search_done;
    logic lo_zero;
    logic lo_at_len;
  } sts_t;

endpackage

>>> sv/tli_ctrl.sv
// controller of the table linear interpolator
// sequences table read, binary search, multiply and serial divide
// depends on tli_pkg
module tli_ctrl import tli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic kind_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic out_valid_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_LAST = 4'd1;
  localparam logic [3:0] S_WT_LAST = 4'd2;
  localparam logic [3:0] S_SRCH    = 4'd3;
  localparam logic [3:0] S_SWAIT   = 4'd4;
  localparam logic [3:0] S_P0      = 4'd5;
  localparam logic [3:0] S_P1      = 4'd6;
  localparam logic [3:0] S_MAG     = 4'd7;
  localparam logic [3:0] S_MUL     = 4'd8;
  localparam logic [3:0] S_SUM     = 4'd9;
  localparam logic [3:0] S_CHK     = 4'd10;
  localparam logic [3:0] S_DIV     = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = S_RD_LAST;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      S_RD_LAST: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ADDR_LAST;
        state_d      = S_WT_LAST;
      end
      S_WT_LAST: begin
        cmd_o.keep_last = 1'b1;
        if (sts_i.gt_last) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_ABOVE;
          state_d        = S_OUT;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (!sts_i.search_done) begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = ADDR_MID;
          cmd_o.mid_load = 1'b1;
          state_d        = S_SWAIT;
        end else if (sts_i.lo_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_LEFT;
          state_d        = S_OUT;
        end else if (sts_i.lo_at_len) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_AT;
          state_d        = S_OUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = ADDR_LOM1;
          state_d      = S_P0;
        end
      end
      S_SWAIT: begin
        cmd_o.step_search = 1'b1;
        state_d           = S_SRCH;
      end
      S_P0: begin
        cmd_o.take_p0 = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = ADDR_LO;
        state_d       = S_P1;
      end
      S_P1: begin
        cmd_o.delta = 1'b1;
        state_d     = S_MAG;
      end
      S_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.check = 1'b1;
        cnt_d       = CNT_W'(QUO_W - 1);
        state_d     = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_INTERP;
        state_d        = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule

>>> sv/tli_datapath.sv
// datapath of the table linear interpolator
// point tables, search registers, split multiplier, restoring divider, result
// depends on tli_pkg
module tli_datapath import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  cmd_t               cmd_i,
  input  in_item_t           item_i,
  input  logic [TLEN_W-1:0]  table_length_i,
  input  logic signed [31:0] left_value_i,
  output sts_t               sts_o,
  output out_item_t          result_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW  = AW + 1;
  localparam int unsigned CW  = (IW > TLEN_W) ? IW : TLEN_W;
  localparam int unsigned DW  = 33;
  localparam int unsigned LOW = 17;
  localparam int unsigned HIW = DW - LOW;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned SW  = 35;

  logic signed [31:0] x_mem [TABLE_DEPTH];
  logic signed [31:0] y_mem [TABLE_DEPTH];
  logic signed [31:0] x_rd_q, y_rd_q;

  logic signed [31:0] z_q, y_last_q, x0_q, y0_q;
  logic [IW-1:0]      len_q, lo_q, hi_q, mid_q;
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  logic [DW-1:0]      dx_mag_q, dy_mag_q, dz_mag_q;
  logic               neg_q, dxz_q, sat_q;
  logic [DW+LOW-1:0]  pp_lo_q;
  logic [DW+HIW-1:0]  pp_hi_q;
  logic [PW-1:0]      rem_q, dsh_q;
  logic [QUO_W-1:0]   quo_q;
  out_item_t          res_q;

  logic [CW-1:0]      len_ext, wr_ext;
  logic [IW-1:0]      len_clamp, mid_d, rd_full;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en, ge_mid, rem_ge;
  logic [SW-1:0]      y0_ext, quo_ext, interp_sum;
  logic signed [31:0] interp_val;

  // length clamp and load address range
  assign len_ext = CW'(table_length_i);
  always_comb begin
    if (len_ext < CW'(2)) begin
      len_clamp = IW'(2);
    end else if (len_ext > CW'(TABLE_DEPTH)) begin
      len_clamp = IW'(TABLE_DEPTH);
    end else begin
      len_clamp = IW'(len_ext);
    end
  end

  assign wr_ext  = CW'(item_i.point_index);
  assign wr_addr = wr_ext[AW-1:0];
  assign wr_en   = cmd_i.write && (wr_ext < CW'(TABLE_DEPTH));

  assign mid_d = lo_q + ((hi_q - lo_q) >> 1);

  always_comb begin
    case (cmd_i.rd_sel)
      ADDR_LAST: rd_full = len_q - 1'b1;
      ADDR_MID:  rd_full = mid_d;
      ADDR_LOM1: rd_full = lo_q - 1'b1;
      ADDR_LO:   rd_full = lo_q;
      default:   rd_full = lo_q;
    endcase
  end
  assign rd_addr = rd_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      x_mem[wr_addr] <= item_i.domain_value;
      y_mem[wr_addr] <= item_i.point_value;
    end
    if (cmd_i.rd_en) begin
      x_rd_q <= x_mem[rd_addr];
      y_rd_q <= y_mem[rd_addr];
    end
  end

  assign ge_mid = (z_q >= x_rd_q);
  assign rem_ge = (rem_q >= dsh_q);

  // search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      z_q   <= item_i.domain_value;
      len_q <= len_clamp;
      lo_q  <= '0;
      hi_q  <= len_clamp;
    end
    if (cmd_i.keep_last) begin
      y_last_q <= y_rd_q;
    end
    if (cmd_i.mid_load) begin
      mid_q <= mid_d;
    end
    if (cmd_i.step_search) begin
      if (ge_mid) begin
        lo_q <= mid_q + 1'b1;
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.take_p0) begin
      x0_q <= x_rd_q;
      y0_q <= y_rd_q;
    end
  end

  // slope arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      dx_q <= {x_rd_q[31], x_rd_q} - {x0_q[31], x0_q};
      dy_q <= {y_rd_q[31], y_rd_q} - {y0_q[31], y0_q};
      dz_q <= {z_q[31], z_q} - {x0_q[31], x0_q};
    end
    if (cmd_i.mag) begin
      dx_mag_q <= dx_q[DW-1] ? (~dx_q + 1'b1) : dx_q;
      dy_mag_q <= dy_q[DW-1] ? (~dy_q + 1'b1) : dy_q;
      dz_mag_q <= dz_q[DW-1] ? (~dz_q + 1'b1) : dz_q;
      neg_q    <= dx_q[DW-1] ^ dy_q[DW-1] ^ dz_q[DW-1];
      dxz_q    <= (dx_q == '0);
    end
    if (cmd_i.mul) begin
      pp_lo_q <= dy_mag_q * dz_mag_q[LOW-1:0];
      pp_hi_q <= dy_mag_q * dz_mag_q[DW-1:LOW];
    end
    if (cmd_i.sum) begin
      rem_q <= PW'(pp_lo_q) + {pp_hi_q, {LOW{1'b0}}};
      dsh_q <= {dx_mag_q, {QUO_W{1'b0}}};
    end
    if (cmd_i.check) begin
      sat_q <= rem_ge;
      dsh_q <= dsh_q >> 1;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // final add and saturation
  assign y0_ext     = SW'(y0_q);
  assign quo_ext    = SW'(quo_q);
  assign interp_sum = neg_q ? (y0_ext - quo_ext) : (y0_ext + quo_ext);

  always_comb begin
    if (dxz_q) begin
      interp_val = y0_q;
    end else if (sat_q) begin
      interp_val = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (interp_sum[SW-1] && !(&interp_sum[SW-2:31])) begin
      interp_val = 32'sh8000_0000;
    end else if (!interp_sum[SW-1] && (|interp_sum[SW-2:31])) begin
      interp_val = 32'sh7fff_ffff;
    end else begin
      interp_val = interp_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      case (cmd_i.res_sel)
        RES_LEFT: begin
          res_q.interpolated_value <= left_value_i;
          res_q.region             <= REGION_BELOW;
        end
        RES_ABOVE: begin
          res_q.interpolated_value <= y_rd_q;
          res_q.region             <= REGION_ABOVE;
        end
        RES_AT: begin
          res_q.interpolated_value <= y_last_q;
          res_q.region             <= REGION_AT_LAST;
        end
        RES_INTERP: begin
          res_q.interpolated_value <= interp_val;
          res_q.region             <= REGION_INTERIOR;
        end
        default: begin
          res_q.interpolated_value <= interp_val;
          res_q.region             <= REGION_INTERIOR;
        end
      endcase
    end
  end

  assign sts_o.gt_last     = (z_q > x_rd_q);
  assign sts_o.search_done = !(lo_q < hi_q);
  assign sts_o.lo_zero     = (lo_q == '0);
  assign sts_o.lo_at_len   = (lo_q == len_q);

  assign result_o = res_q;

endmodule

>>> sv/table_linear_interpolator_core.sv
// top level of the table linear interpolator: config registers, controller, datapath
// depends on tli_pkg, tli_ctrl, tli_datapath
//
// channel   direction  handshake                     payload
// -------   ---------  ----------------------------  ------------------------
// item      in         start high while busy low     item_i (in_item_t)
// result    out        out_valid_o strobe, 1 cycle   result_o (out_item_t)
// config    in         cfg_valid_i and cfg_ready_o   cfg_index_i, cfg_data_i
//
// a load item writes one point in its accept cycle and leaves busy low
// a query above the last x reads the last point and ends; one below the first x or at the
//   last x ends when the binary search is done; an interior query then reads its two points
//   and runs the delta, magnitude, multiply, sum, check and divide steps; each search step
//   waits on the registered table read; the divider yields one quotient bit per cycle
// reset returns the controller to idle, sets the table length to 2 and clears the left value;
// table contents stay undefined; the result strobe cannot be held off: it lasts one cycle, then busy falls
module table_linear_interpolator_core import tli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        out_valid_o,
  output out_item_t   result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [TLEN_W-1:0]  table_length_q;
  logic signed [31:0] left_value_q;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= TLEN_W'(2);
      left_value_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TABLE_LENGTH: table_length_q <= cfg_data_i[TLEN_W-1:0];
        REG_LEFT_VALUE:   left_value_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (item_i.kind),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (out_valid_o)
  );

  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .table_length_i (table_length_q),
    .left_value_i   (left_value_q),
    .sts_o          (sts),
    .result_o       (result_o)
  );

  a_result_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result strobe outside a query");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_load_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_LOAD) |=> (!busy && !out_valid_o))
    else $error("load item started a query");

  a_query_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_QUERY) |=> (busy && !out_valid_o))
    else $error("query item not taken up");

endmodule
